// ===== rtl/core/button_click_classifier_unit_defines.svh =====
// Assertion macros for the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, held off while reset is high.
`define BCC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define BCC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BCC_ASSERT(label, clk, rst, prop, msg)
`define BCC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/core/btnclk_pkg.sv =====
// Shared types and constants for the button click classifier.
package btnclk_pkg;

  // Click event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_SINGLE = 3'd1;
  localparam logic [2:0] EV_DOUBLE = 3'd2;
  localparam logic [2:0] EV_TRIPLE = 3'd3;
  localparam logic [2:0] EV_LONG   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;

  // Configuration reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] LONG_RST     = 16'd1000;
  localparam logic [15:0] WINDOW_RST   = 16'd250;

  localparam int NOW_W      = 32;
  localparam int CFG_W      = 16;
  localparam logic [7:0] TALLY_MAX = 8'd255;

  // One result item
  typedef struct packed {
    logic [2:0] last_click_kind;
    logic [7:0] clicks_pending;
    logic       is_pressed;
    logic [2:0] click_event;
  } result_t;

endpackage

// ===== rtl/core/button_click_classifier_unit.sv =====
// Button click classifier: poll-driven single, double, triple and long click detection.
// Datapath: an input register followed by a result register.
// Throughput: one poll per cycle; a stalled result holds the input register, so the
//   input stops once that register is full as well.
// Reset: synchronous; clears the click state, restores the register defaults
//   (debounce 50, long 1000, window 250) and empties both registers.
`include "button_click_classifier_unit_defines.svh"

module button_click_classifier_unit
  import btnclk_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Input poll stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] click_event, [3] is_pressed,
                                 // [11:4] clicks_pending, [14:12] last_click_kind, [15] zero
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NOW_KEEP = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

  // Configuration registers
  logic [CFG_W-1:0] debounce_lim;
  logic [CFG_W-1:0] long_click_ms;
  logic [CFG_W-1:0] multi_click_window_ms;

  // Click state
  logic                 level_now;
  logic [TIME_BITS-1:0] press_stamp;
  logic [TIME_BITS-1:0] window_stamp;
  logic [7:0]           press_tally;
  logic                 long_seen;
  logic                 debounce_passed;
  logic [2:0]           last_kind;

  // Input register
  logic             in_valid;
  logic             in_pin;
  logic [NOW_W-1:0] in_now;

  // Result register
  logic    out_valid;
  result_t out_result;

  // Next values
  logic                 level_now_next;
  logic [TIME_BITS-1:0] press_stamp_next;
  logic [TIME_BITS-1:0] window_stamp_next;
  logic [7:0]           press_tally_next;
  logic                 long_seen_next;
  logic                 debounce_passed_next;
  logic [2:0]           last_kind_next;
  logic [2:0]           event_next;

  logic                 advance;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] since_window;
  logic                 held_deb_ok;
  logic                 held_long_ok;
  logic                 window_over;
  logic                 fall;
  logic                 rise;

  // Handshake control
  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {1'b0, out_result};

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_lim          <= DEBOUNCE_RST;
      long_click_ms         <= LONG_RST;
      multi_click_window_ms <= WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_lim          <= cfg_data;
        REG_LONG:     long_click_ms         <= cfg_data;
        REG_WINDOW:   multi_click_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pin <= s_tdata[0];
      in_now <= s_tdata[32:1];
    end
  end

  // Elapsed times, modulo the timestamp width
  assign now_t        = TIME_BITS'(in_now[NOW_KEEP-1:0]);
  assign held         = now_t - press_stamp;
  assign since_window = now_t - window_stamp;
  assign held_deb_ok  = held >= TIME_BITS'(debounce_lim);
  assign held_long_ok = held >= TIME_BITS'(long_click_ms);
  assign window_over  = since_window > TIME_BITS'(multi_click_window_ms);
  assign fall         = level_now && !in_pin;
  assign rise         = !level_now && in_pin;

  // Click state update for the poll in the input register
  always_comb begin
    level_now_next       = in_pin;
    press_stamp_next     = press_stamp;
    window_stamp_next    = window_stamp;
    press_tally_next     = press_tally;
    long_seen_next       = long_seen;
    debounce_passed_next = debounce_passed;
    last_kind_next       = last_kind;
    event_next           = EV_NONE;

    if (fall) begin
      press_stamp_next     = now_t;
      window_stamp_next    = now_t;
      debounce_passed_next = 1'b0;
      if (press_tally != TALLY_MAX) begin
        press_tally_next = press_tally + 8'd1;
      end
    end else if (rise) begin
      if (held_deb_ok && held_long_ok) begin
        long_seen_next = 1'b1;
      end
    end else if (in_pin && !debounce_passed && held_deb_ok) begin
      // this poll only arms the debounce flag
      debounce_passed_next = 1'b1;
    end else if (in_pin && window_over) begin
      // window expired: classify and clear
      if (long_seen) begin
        if (press_tally == 8'd1) begin
          event_next = EV_LONG;
        end
        long_seen_next = 1'b0;
      end else begin
        case (press_tally)
          8'd1:    event_next = EV_SINGLE;
          8'd2:    event_next = EV_DOUBLE;
          8'd3:    event_next = EV_TRIPLE;
          default: event_next = EV_NONE;
        endcase
      end
      if (event_next != EV_NONE) begin
        last_kind_next = event_next;
      end
      press_tally_next  = 8'd0;
      window_stamp_next = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_now       <= 1'b1;
      press_stamp     <= '0;
      window_stamp    <= '0;
      press_tally     <= 8'd0;
      long_seen       <= 1'b0;
      debounce_passed <= 1'b0;
      last_kind       <= EV_NONE;
    end else if (advance) begin
      level_now       <= level_now_next;
      press_stamp     <= press_stamp_next;
      window_stamp    <= window_stamp_next;
      press_tally     <= press_tally_next;
      long_seen       <= long_seen_next;
      debounce_passed <= debounce_passed_next;
      last_kind       <= last_kind_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result.click_event     <= event_next;
      out_result.is_pressed      <= !in_pin;
      out_result.clicks_pending  <= press_tally_next;
      out_result.last_click_kind <= last_kind_next;
    end
  end

  // Checks
  `BCC_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(rst) |-> !m_tvalid, "result valid right after reset")
  `BCC_ASSERT(a_stall_blocks_input, clk, rst, (in_valid && out_valid && !m_tready) |-> !s_tready, "input taken while both registers full")
  `BCC_ASSERT(a_event_sets_kind, clk, rst, (m_tvalid && m_tdata[2:0] != EV_NONE) |-> (m_tdata[14:12] == m_tdata[2:0]), "event does not match last kind")
  `BCC_ASSERT(a_event_clears_tally, clk, rst, (m_tvalid && m_tdata[2:0] != EV_NONE) |-> (m_tdata[11:4] == 8'd0), "event left clicks pending")
  `BCC_ASSERT(a_tally_saturates, clk, rst, (advance && fall && press_tally == TALLY_MAX) |=> (press_tally == TALLY_MAX), "press count wrapped")

endmodule
